[sv/occ_pkg.sv]
// Shared types and constants for the octree occupancy encoder.
`timescale 1ns / 1ps

package occ_pkg;

    localparam int CODE_W  = 30;
    localparam int NODE_W  = 27;
    localparam int LVL_W   = 4;
    localparam int MASK_W  = 8;
    localparam int DEPTH_W = 4;
    localparam int SHIFT_W = 6;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd10;

    typedef struct packed {
        logic [LVL_W-1:0]  level;
        logic [NODE_W-1:0] node;
        logic [MASK_W-1:0] mask;
        logic              err;
    } occ_rec_t;

    // Front to queue: one record write and the end-of-item strobe.
    typedef struct packed {
        logic     push;
        logic     done;
        occ_rec_t rec;
    } occ_push_t;

    // Queue to back: oldest record that is ready to leave.
    typedef struct packed {
        logic     avail;
        logic     run_end;
        occ_rec_t rec;
    } occ_head_t;

    typedef enum logic [1:0] {
        FR_EVAL,
        FR_CLOSE,
        FR_FLUSH
    } front_state_t;

endpackage

[sv/occ_front.sv]
// Front end: takes point items, tracks open nodes and generates node records.
`timescale 1ns / 1ps

module occ_front #(
    parameter int MAX_DEPTH = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [occ_pkg::DEPTH_W-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [occ_pkg::CODE_W-1:0] leaf_code,
    input  logic                       final_point,
    input  logic                       q_room,
    output occ_pkg::occ_push_t         push_o
);
    import occ_pkg::*;

    localparam int IW = $clog2((MAX_DEPTH > 1) ? MAX_DEPTH : 2);
    localparam int WIDE_W = 3 * MAX_DEPTH + CODE_W;

    logic [DEPTH_W-1:0] depth_reg;
    logic               hold_v_reg;
    logic [CODE_W-1:0]  hold_code_reg;
    logic               hold_fin_reg;
    front_state_t       state_reg, state_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [LVL_W-1:0]   first_reg, first_next;
    logic               seen_reg;
    logic [CODE_W-1:0]  prev_reg;
    logic [MASK_W-1:0]  mask_reg [MAX_DEPTH];

    logic [DEPTH_W-1:0] d;
    logic [SHIFT_W-1:0] code_bits;
    logic [CODE_W-1:0]  in_code;
    logic               accept;
    logic               is_err;
    logic               is_dup;
    logic [CODE_W-1:0]  diff;
    logic [WIDE_W-1:0]  diff_wide;
    logic [WIDE_W-1:0]  code_wide;
    logic [LVL_W-1:0]   jmax;
    logic [LVL_W-1:0]   first_c;
    logic [2:0]         lvl_digit [MAX_DEPTH];
    logic [IW-1:0]      lidx;
    logic [SHIFT_W-1:0] node_shift;
    occ_rec_t           node_rec;
    occ_rec_t           err_rec;
    logic               upd;
    logic [LVL_W-1:0]   upd_first;
    logic               clr;
    logic               done;
    logic               push_req;
    occ_rec_t           rec_sel;

    // Tree depth saturated to the supported range.
    always_comb
    begin
        if (depth_reg == '0)
            d = DEPTH_W'(1);
        else if (int'(depth_reg) > MAX_DEPTH)
            d = DEPTH_W'(MAX_DEPTH);
        else
            d = depth_reg;
    end

    assign code_bits = SHIFT_W'(3) * SHIFT_W'(d);

    always_comb
    begin
        for (int b = 0; b < CODE_W; b++)
            in_code[b] = leaf_code[b] & (b < int'(code_bits));
    end

    assign is_err    = seen_reg && (hold_code_reg < prev_reg);
    assign is_dup    = seen_reg && (hold_code_reg == prev_reg);
    assign diff      = hold_code_reg ^ prev_reg;
    assign diff_wide = {{(3 * MAX_DEPTH){1'b0}}, diff};
    assign code_wide = {{(3 * MAX_DEPTH){1'b0}}, hold_code_reg};

    // Highest differing digit decides how many levels close.
    always_comb
    begin
        jmax = '0;
        for (int j = 0; j < MAX_DEPTH; j++)
        begin
            if (diff_wide[3 * j +: 3] != 3'b000)
                jmax = LVL_W'(j);
        end
    end

    assign first_c = seen_reg ? (d - jmax) : '0;

    // Level l takes its child index from digit d-1-l of the code.
    always_comb
    begin
        for (int l = 0; l < MAX_DEPTH; l++)
        begin
            lvl_digit[l] = 3'b000;
            for (int j = 0; j < MAX_DEPTH; j++)
            begin
                if (j == int'(d) - 1 - l)
                    lvl_digit[l] = code_wide[3 * j +: 3];
            end
        end
    end

    assign lidx       = IW'(lvl_reg);
    assign node_shift = SHIFT_W'(3) * SHIFT_W'(d - lvl_reg);

    always_comb
    begin
        node_rec.level = lvl_reg;
        node_rec.node  = NODE_W'(prev_reg >> node_shift);
        node_rec.mask  = mask_reg[lidx];
        node_rec.err   = 1'b0;
        err_rec        = '0;
        err_rec.err    = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        first_next = first_reg;
        push_req   = 1'b0;
        rec_sel    = node_rec;
        upd        = 1'b0;
        upd_first  = first_c;
        clr        = 1'b0;
        done       = 1'b0;
        case (state_reg)
            FR_EVAL:
            begin
                if (hold_v_reg)
                begin
                    if (is_err)
                    begin
                        push_req = 1'b1;
                        rec_sel  = err_rec;
                        if (q_room)
                        begin
                            if (hold_fin_reg)
                            begin
                                state_next = FR_FLUSH;
                                lvl_next   = d - LVL_W'(1);
                            end
                            else
                                done = 1'b1;
                        end
                    end
                    else if (is_dup)
                    begin
                        if (hold_fin_reg)
                        begin
                            state_next = FR_FLUSH;
                            lvl_next   = d - LVL_W'(1);
                        end
                        else
                            done = 1'b1;
                    end
                    else if (seen_reg && jmax != '0)
                    begin
                        state_next = FR_CLOSE;
                        lvl_next   = d - LVL_W'(1);
                        first_next = first_c;
                    end
                    else
                    begin
                        upd = 1'b1;
                        if (hold_fin_reg)
                        begin
                            state_next = FR_FLUSH;
                            lvl_next   = d - LVL_W'(1);
                        end
                        else
                            done = 1'b1;
                    end
                end
            end
            FR_CLOSE:
            begin
                push_req = 1'b1;
                if (q_room)
                begin
                    if (lvl_reg == first_reg)
                    begin
                        upd       = 1'b1;
                        upd_first = first_reg;
                        if (hold_fin_reg)
                        begin
                            state_next = FR_FLUSH;
                            lvl_next   = d - LVL_W'(1);
                        end
                        else
                        begin
                            state_next = FR_EVAL;
                            done       = 1'b1;
                        end
                    end
                    else
                        lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            FR_FLUSH:
            begin
                push_req = 1'b1;
                if (q_room)
                begin
                    if (lvl_reg == '0)
                    begin
                        clr        = 1'b1;
                        done       = 1'b1;
                        state_next = FR_EVAL;
                    end
                    else
                        lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            default:
            begin
                state_next = FR_EVAL;
            end
        endcase
    end

    assign in_ready    = !hold_v_reg || done;
    assign accept      = in_valid && in_ready;
    assign push_o.push = push_req && q_room;
    assign push_o.done = done;
    assign push_o.rec  = rec_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FR_EVAL;
            hold_v_reg <= 1'b0;
            depth_reg  <= DEPTH_RESET;
            seen_reg   <= 1'b0;
            prev_reg   <= '0;
            lvl_reg    <= '0;
            first_reg  <= '0;
            for (int l = 0; l < MAX_DEPTH; l++)
                mask_reg[l] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
            first_reg <= first_next;
            if (accept)
                hold_v_reg <= 1'b1;
            else if (done)
                hold_v_reg <= 1'b0;
            if (cfg_we)
                depth_reg <= cfg_wdata;
            if (cfg_we || clr)
            begin
                seen_reg <= 1'b0;
                prev_reg <= '0;
            end
            else if (upd)
            begin
                seen_reg <= 1'b1;
                prev_reg <= hold_code_reg;
            end
            for (int l = 0; l < MAX_DEPTH; l++)
            begin
                if (cfg_we || clr)
                    mask_reg[l] <= '0;
                else if (upd && l < int'(d))
                begin
                    if (l < int'(upd_first))
                        mask_reg[l] <= mask_reg[l] | (MASK_W'(1) << lvl_digit[l]);
                    else
                        mask_reg[l] <= MASK_W'(1) << lvl_digit[l];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_code_reg <= in_code;
            hold_fin_reg  <= final_point;
        end
    end

endmodule

[sv/occ_recq.sv]
// Record queue between front and back, with per-item grouping and overflow drop.
`timescale 1ns / 1ps

module occ_recq #(
    parameter int MAX_DEPTH = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  occ_pkg::occ_push_t push_i,
    output logic               room,
    output occ_pkg::occ_head_t head_o,
    input  logic               pop
);
    import occ_pkg::*;

    localparam int QCAP  = 2 * MAX_DEPTH + 2;
    localparam int CW    = $clog2(QCAP + 1);
    localparam int AW    = $clog2(QCAP + 1);
    localparam int DEPTH = 1 << AW;

    occ_rec_t         rec_mem [DEPTH];
    logic [DEPTH-1:0] end_reg;
    logic [AW:0]      head_reg;
    logic [AW:0]      asg_reg;
    logic [AW:0]      wr_reg;
    logic [CW-1:0]    cnt_reg;

    logic [AW:0]      fill;
    logic             wr_en;
    logic [CW-1:0]    cnt_after;
    logic [CW-1:0]    n_take;
    logic [AW:0]      end_ptr;
    logic             end_set;

    // Records not yet tied to an item are the pending queue; at most QCAP
    // of them are kept and the rest are dropped.
    assign fill      = wr_reg - head_reg;
    assign room      = (fill != (AW + 1)'(DEPTH));
    assign wr_en     = push_i.push && (int'(cnt_reg) < QCAP);
    assign cnt_after = cnt_reg + CW'(wr_en);

    always_comb
    begin
        n_take = '0;
        if (push_i.done)
        begin
            if (int'(cnt_after) > MAX_DEPTH)
                n_take = CW'(MAX_DEPTH);
            else
                n_take = cnt_after;
        end
    end

    assign end_set = (n_take != '0);
    assign end_ptr = asg_reg + (AW + 1)'(n_take) - (AW + 1)'(1);

    assign head_o.avail   = (asg_reg != head_reg);
    assign head_o.run_end = end_reg[head_reg[AW-1:0]];
    assign head_o.rec     = rec_mem[head_reg[AW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            asg_reg  <= '0;
            wr_reg   <= '0;
            cnt_reg  <= '0;
            end_reg  <= '0;
        end
        else
        begin
            if (pop)
                head_reg <= head_reg + (AW + 1)'(1);
            if (cfg_we)
            begin
                wr_reg  <= asg_reg;
                cnt_reg <= '0;
            end
            else
            begin
                if (wr_en)
                    wr_reg <= wr_reg + (AW + 1)'(1);
                asg_reg <= asg_reg + (AW + 1)'(n_take);
                cnt_reg <= cnt_after - n_take;
            end
            for (int i = 0; i < DEPTH; i++)
            begin
                if (end_set && end_ptr[AW-1:0] == AW'(i))
                    end_reg[i] <= 1'b1;
                else if (wr_en && wr_reg[AW-1:0] == AW'(i))
                    end_reg[i] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            rec_mem[wr_reg[AW-1:0]] <= push_i.rec;
    end

endmodule

[sv/occ_back.sv]
// Back end: output register that hands records to the receiver.
`timescale 1ns / 1ps

module occ_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  occ_pkg::occ_head_t         head_i,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [occ_pkg::LVL_W-1:0]  tree_level,
    output logic [occ_pkg::NODE_W-1:0] node_code,
    output logic [occ_pkg::MASK_W-1:0] child_mask,
    output logic                       order_error,
    output logic                       run_end
);
    import occ_pkg::*;

    logic     valid_reg;
    occ_rec_t rec_reg;
    logic     end_reg;

    assign pop = head_i.avail && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || out_ready)
            valid_reg <= head_i.avail;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rec_reg <= head_i.rec;
            end_reg <= head_i.run_end;
        end
    end

    assign out_valid   = valid_reg;
    assign tree_level  = rec_reg.level;
    assign node_code   = rec_reg.node;
    assign child_mask  = rec_reg.mask;
    assign order_error = rec_reg.err;
    assign run_end     = end_reg;

endmodule

[sv/octree_occupancy_encoder.sv]
// Streaming octree occupancy encoder: top level.
// Input channel: in_valid/in_ready carrying leaf_code (Morton code, ascending)
// and final_point, which marks the last point of a cloud and flushes all levels.
// Output channel: out_valid/out_ready carrying node records:
// tree_level, node_code, child_mask, order_error and run_end, the last of which
// marks the final record of the group released for one input item.
// The front evaluates a held item and then writes one close or flush record per
// cycle while the queue has room; an order error record is written in the
// evaluating state itself. A point that closes no node is taken every cycle as
// long as the queue has room. Records of an item, up to MAX_DEPTH of them, are
// released to the back together once the front is done with it, and the back
// then loads the first one into its output register. Records flow through a
// queue of 2*MAX_DEPTH+2 pending entries plus room for grouped ones; the front
// stalls only when the whole record memory is full, and the back returns one
// record a cycle while the receiver is ready.
// A stalled receiver holds the output register while the queue keeps filling.
// Reset empties the queue, clears all open nodes and sets tree_depth to 10.
// A write on cfg_we loads tree_depth and abandons the open cloud.
`timescale 1ns / 1ps

module octree_occupancy_encoder #(
    parameter int MAX_DEPTH = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [occ_pkg::DEPTH_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [occ_pkg::CODE_W-1:0]  leaf_code,
    input  logic                        final_point,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [occ_pkg::LVL_W-1:0]   tree_level,
    output logic [occ_pkg::NODE_W-1:0]  node_code,
    output logic [occ_pkg::MASK_W-1:0]  child_mask,
    output logic                        order_error,
    output logic                        run_end
);
    import occ_pkg::*;

    occ_push_t push_s;
    occ_head_t head_s;
    logic      room_s;
    logic      pop_s;

    occ_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .leaf_code   (leaf_code),
        .final_point (final_point),
        .q_room      (room_s),
        .push_o      (push_s)
    );

    occ_recq #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_recq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_we (cfg_we),
        .push_i (push_s),
        .room   (room_s),
        .head_o (head_s),
        .pop    (pop_s)
    );

    occ_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_i      (head_s),
        .pop         (pop_s),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tree_level  (tree_level),
        .node_code   (node_code),
        .child_mask  (child_mask),
        .order_error (order_error),
        .run_end     (run_end)
    );

endmodule

[tb/sv/octree_occupancy_encoder_tb.sv]
// Self-checking testbench for the octree occupancy encoder: Morton code stream in, node records out.
`timescale 1ns / 1ps

module octree_occupancy_encoder_tb;
    import occ_pkg::*;

    localparam int MAX_LVL      = 10;
    localparam int BACKLOG_CAP  = 2 * MAX_LVL + 2;
    localparam int LONG_HOLD    = 250;
    localparam int SETTLE       = 40;
    localparam int LIMIT_CYCLES = 500000;
    localparam int MAX_REPORTS  = 10;

    // Phase variants.
    localparam int PH_PLAIN = 0;
    localparam int PH_HOLD  = 1;
    localparam int PH_PAUSE = 2;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              fin;
    } point_t;

    typedef struct packed {
        occ_rec_t rec;
        logic     run_end;
    } node_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [DEPTH_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CODE_W-1:0] leaf_code = '0;
    logic final_point = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [LVL_W-1:0] tree_level;
    logic [NODE_W-1:0] node_code;
    logic [MASK_W-1:0] child_mask;
    logic order_error;
    logic run_end;

    octree_occupancy_encoder #(
        .MAX_DEPTH(MAX_LVL)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .leaf_code(leaf_code),
        .final_point(final_point),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .tree_level(tree_level),
        .node_code(node_code),
        .child_mask(child_mask),
        .order_error(order_error),
        .run_end(run_end)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Tracked encoder state.
    logic [DEPTH_W-1:0] depth_reg = DEPTH_RESET;
    logic [NODE_W-1:0]  trk_node [MAX_LVL];
    logic [MASK_W-1:0]  trk_mask [MAX_LVL];
    bit                 cloud_open;
    longint unsigned    last_code;
    occ_rec_t           rec_backlog [$];
    node_rec_t          pending_recs [$];

    point_t point_q [$];
    int     idle_odds = 4;
    bit     hold_go = 1'b0;
    bit     hold_done;
    int     hold_count;
    int     gap_left;
    int     stall_left;
    int     fail_count = 0;
    int     cycle_count = 0;
    node_rec_t want;

    function automatic int eff_depth(logic [DEPTH_W-1:0] v);
        if (v < 1)
            return 1;
        if (v > MAX_LVL)
            return MAX_LVL;
        return int'(v);
    endfunction

    task automatic clear_open();
        for (int l = 0; l < MAX_LVL; l++)
        begin
            trk_node[l] = '0;
            trk_mask[l] = '0;
        end
        cloud_open = 1'b0;
        last_code = 0;
    endtask

    task automatic queue_rec(int lvl, longint unsigned node, logic [MASK_W-1:0] m, bit e);
        occ_rec_t r;
        if (rec_backlog.size() < BACKLOG_CAP)
        begin
            r.level = lvl[LVL_W-1:0];
            r.node = node[NODE_W-1:0];
            r.mask = m;
            r.err = e;
            rec_backlog = {rec_backlog, r};
        end
    endtask

    // Closes the nodes that a new point leaves, opens its own, flushes on the last
    // point, and hands out at most MAX_LVL backlog records per item.
    task automatic encode_point(logic [CODE_W-1:0] raw, logic fin);
        int d;
        int first;
        int n;
        longint unsigned code;
        logic [MASK_W-1:0] bitv;
        node_rec_t x;
        d = eff_depth(depth_reg);
        code = longint'(raw) & ((64'd1 << (3 * d)) - 1);
        if (cloud_open && code < last_code)
            queue_rec(0, 0, '0, 1'b1);
        else if (!cloud_open || code != last_code)
        begin
            first = 0;
            if (cloud_open)
            begin
                first = d;
                for (int l = 0; l < d; l++)
                begin
                    if ((code >> (3 * (d - l))) != trk_node[l])
                    begin
                        first = l;
                        break;
                    end
                end
                for (int l = d - 1; l >= first; l--)
                    queue_rec(l, trk_node[l], trk_mask[l], 1'b0);
            end
            for (int l = 0; l < d; l++)
            begin
                bitv = 8'd1 << ((code >> (3 * (d - 1 - l))) & 7);
                if (l >= first)
                begin
                    trk_node[l] = NODE_W'(code >> (3 * (d - l)));
                    trk_mask[l] = bitv;
                end
                else
                    trk_mask[l] = trk_mask[l] | bitv;
            end
            cloud_open = 1'b1;
            last_code = code;
        end
        if (fin)
        begin
            if (cloud_open)
                for (int l = d - 1; l >= 0; l--)
                    queue_rec(l, trk_node[l], trk_mask[l], 1'b0);
            clear_open();
        end
        n = 0;
        while (rec_backlog.size() > 0 && n < MAX_LVL)
        begin
            x.rec = rec_backlog.pop_front();
            x.run_end = (rec_backlog.size() == 0) || (n == MAX_LVL - 1);
            pending_recs = {pending_recs, x};
            n++;
        end
    endtask

    // Sender: one item offered at a time, random gaps after acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            leaf_code <= '0;
            final_point <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                encode_point(leaf_code, final_point);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (point_q.size() > 0)
                begin
                    point_t p;
                    p = point_q.pop_front();
                    in_valid <= 1'b1;
                    leaf_code <= p.code;
                    final_point <= p.fin;
                    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                        gap_left <= $urandom_range(1, 13);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
            hold_count <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == LONG_HOLD - 1)
                hold_done <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1)
                stall_left <= $urandom_range(1, 13);
        end
    end

    // Checker: each record against the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_recs.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected record: lvl %0d node %h mask %h err %b end %b",
                             tree_level, node_code, child_mask, order_error, run_end);
            end
            else
            begin
                want = pending_recs.pop_front();
                if (tree_level !== want.rec.level || node_code !== want.rec.node ||
                    child_mask !== want.rec.mask || order_error !== want.rec.err ||
                    run_end !== want.run_end)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("record mismatch: expected lvl %0d node %h mask %h err %b end %b",
                                 want.rec.level, want.rec.node, want.rec.mask, want.rec.err,
                                 want.run_end);
                        $display("                 got      lvl %0d node %h mask %h err %b end %b",
                                 tree_level, node_code, child_mask, order_error, run_end);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic add_point(longint unsigned code, bit fin);
        point_t p;
        p.code = code[CODE_W-1:0];
        p.fin = fin;
        point_q = {point_q, p};
    endtask

    // One cloud: mostly ascending codes, with repeats, drops below the previous
    // code and stray codes mixed in; junk above the tree bits on some items.
    task automatic add_cloud(int n);
        int d;
        int k;
        int r;
        longint unsigned span;
        longint unsigned cur;
        longint unsigned step;
        longint unsigned val;
        longint unsigned junk;
        d = eff_depth(depth_reg);
        span = (64'd1 << (3 * d)) - 1;
        cur = (longint'($urandom) & span) >> $urandom_range(2, 3 * d);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (i > 0 && r < 5 && cur > 0)
                val = cur - 1 - ({$urandom, $urandom} % cur);
            else if (i > 0 && r < 12)
                val = cur;
            else if (i > 0 && r < 15)
            begin
                val = longint'($urandom) & span;
                if (val >= cur)
                    cur = val;
            end
            else
            begin
                if (i > 0)
                begin
                    k = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6) : $urandom_range(0, 3 * d);
                    step = 1 + ({$urandom, $urandom} & ((64'd1 << k) - 1));
                    cur = (cur + step > span) ? span : cur + step;
                end
                val = cur;
            end
            junk = $urandom_range(0, 1) ? (longint'($urandom) & ~span) : 0;
            add_point(val | junk, i == n - 1);
        end
    endtask

    // A last point, then two points that take no record of their own, so that any
    // records left over from the flush go out before the block is left idle.
    task automatic add_drain();
        add_point(longint'($urandom), 1'b1);
        add_point(0, 1'b0);
        add_point(0, 1'b0);
    endtask

    task automatic wait_drained();
        while (point_q.size() != 0 || in_valid || pending_recs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_depth(logic [DEPTH_W-1:0] v);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        depth_reg = v;
        clear_open();
        rec_backlog.delete();
    endtask

    task automatic run_phase(logic [DEPTH_W-1:0] depth, int clouds, int size_max, int odds,
                             int variant);
        write_depth(depth);
        idle_odds = odds;
        for (int c = 0; c < clouds; c++)
        begin
            if (variant == PH_PAUSE && c == clouds / 2)
                wait_drained();
            add_cloud($urandom_range(1, size_max));
        end
        add_drain();
        if (variant == PH_HOLD)
        begin
            @(posedge clk);
            hold_go <= 1'b1;
            while (!hold_done)
                @(posedge clk);
            hold_go <= 1'b0;
        end
    endtask

    initial
    begin
        clear_open();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: edge codes, repeats, order errors, flushes with leftovers.
        add_point(0, 1'b0);
        add_point(0, 1'b0);
        add_point(1, 1'b0);
        add_point(7, 1'b0);
        add_point(8, 1'b0);
        add_point(63, 1'b0);
        add_point(64, 1'b0);
        add_point(4096, 1'b0);
        add_point(5, 1'b0);
        add_point(30'h3FFF_FFFF, 1'b1);
        add_point(0, 1'b0);
        add_point(30'h2000_0000, 1'b0);
        add_point(30'h10, 1'b0);
        add_point(30'h10, 1'b1);
        add_point(30'h3FFF_FFFF, 1'b1);
        add_point(12345, 1'b0);
        add_point(12345, 1'b1);
        add_drain();

        run_phase(4'd1, 8, 8, 3, PH_PLAIN);
        run_phase(4'd15, 5, 24, 5, PH_HOLD);
        run_phase(4'd0, 8, 8, 2, PH_PLAIN);
        run_phase(4'd3, 6, 14, 6, PH_PLAIN);
        run_phase(4'd7, 5, 20, 4, PH_PAUSE);
        run_phase(4'd10, 3, 30, 8, PH_PLAIN);
        run_phase(4'd2, 6, 10, 3, PH_PLAIN);
        run_phase(DEPTH_W'($urandom_range(0, 15)), 4, 20, 5, PH_PLAIN);
        run_phase(4'd10, 1, 30, 0, PH_PLAIN);

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending_recs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
